// File: rtl/clipped_quad_blitter_assert.svh
// ----------------------------------------------------------------------------
// Clipped quad blitter assertion macros
// Property wrappers used by the port-level checker of the blitter.
// ----------------------------------------------------------------------------
`ifndef CLIPPED_QUAD_BLITTER_ASSERT_SVH
`define CLIPPED_QUAD_BLITTER_ASSERT_SVH

// checked outside reset
`define CQB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define CQB_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: rtl/cqb_pkg.sv
// ----------------------------------------------------------------------------
// Clipped quad blitter package
// Shared types, widths and codes of the blitter.
// ----------------------------------------------------------------------------
package cqb_pkg;

   localparam int FRAME_WIDTH_DEF  = 1024;
   localparam int FRAME_HEIGHT_DEF = 1024;
   localparam int ATLAS_SIZE_DEF   = 128;

   localparam int COORD_W     = 12;
   localparam int SPAN_W      = 14;
   localparam int TEXEL_W     = 9;
   localparam int TEX_POS_W   = 7;
   localparam int TEX_SIZE_W  = 8;
   localparam int COLOUR_W    = 8;
   localparam int PIXEL_W     = 24;
   localparam int COUNT_W     = 21;
   localparam int CSR_INDEX_W = 2;

   localparam logic [1:0] ACT_DRAW = 2'd0;
   localparam logic [1:0] ACT_LOAD = 2'd1;
   localparam logic [1:0] ACT_READ = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_CLIP_LEFT   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLIP_TOP    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLIP_WIDTH  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLIP_HEIGHT = 2'd3;

   localparam logic [COORD_W-1:0] CLIP_SIZE_RESET = 12'd1024;

   typedef struct packed {
      logic [1:0]                  action;
      logic signed [COORD_W-1:0]   dest_x;
      logic signed [COORD_W-1:0]   dest_y;
      logic [COORD_W-1:0]          dest_w;
      logic [COORD_W-1:0]          dest_h;
      logic [TEX_POS_W-1:0]        tex_x;
      logic [TEX_POS_W-1:0]        tex_y;
      logic [TEX_SIZE_W-1:0]       tex_w;
      logic [TEX_SIZE_W-1:0]       tex_h;
      logic [COLOUR_W-1:0]         red;
      logic [COLOUR_W-1:0]         green;
      logic [COLOUR_W-1:0]         blue;
   } cqb_req_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_value;
      logic [COUNT_W-1:0] pixels_drawn;
   } cqb_rsp_type;

   typedef struct packed {
      logic clear_step;
      logic accept;
      logic setup;
      logic start;
      logic fill_step;
      logic tex_wr;
      logic finish;
   } cqb_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic is_draw;
      logic empty;
      logic textured;
      logic last_pixel;
      logic out_free;
   } cqb_sts_type;

endpackage

// File: rtl/cqb_ram.sv
// ----------------------------------------------------------------------------
// Clipped quad blitter RAM
// Generic one-write, one-read memory with registered read data.
// ----------------------------------------------------------------------------
module cqb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     write_en,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data_ff <= mem_ff[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

// File: rtl/cqb_ctrl.sv
// ----------------------------------------------------------------------------
// Clipped quad blitter controller
// Sequences the clearing pass, item decode, pixel walk and result hand-off.
// ----------------------------------------------------------------------------
module cqb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  cqb_pkg::cqb_sts_type sts,
   output cqb_pkg::cqb_cmd_type cmd
);

   typedef enum logic [7:0] {
      S_CLEAR  = 8'b0000_0001,
      S_IDLE   = 8'b0000_0010,
      S_SETUP  = 8'b0000_0100,
      S_START  = 8'b0000_1000,
      S_FILL   = 8'b0001_0000,
      S_TEX_RD = 8'b0010_0000,
      S_TEX_WR = 8'b0100_0000,
      S_FINISH = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_SETUP;
            end
         end
         S_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = sts.is_draw ? S_START : S_FINISH;
         end
         S_START: begin
            cmd.start = 1'b1;
            if (sts.empty) begin
               state_in = S_FINISH;
            end else if (sts.textured) begin
               state_in = S_TEX_RD;
            end else begin
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            cmd.fill_step = 1'b1;
            if (sts.last_pixel) begin
               state_in = S_FINISH;
            end
         end
         S_TEX_RD: begin
            state_in = S_TEX_WR;
         end
         S_TEX_WR: begin
            cmd.tex_wr = 1'b1;
            state_in   = sts.last_pixel ? S_FINISH : S_TEX_RD;
         end
         S_FINISH: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

// File: rtl/cqb_datapath.sv
// ----------------------------------------------------------------------------
// Clipped quad blitter datapath
// Clip registers, rectangle setup, pixel walker, frame and atlas memories,
// and the result register.
// ----------------------------------------------------------------------------
module cqb_datapath #(
   parameter int FRAME_WIDTH  = cqb_pkg::FRAME_WIDTH_DEF,
   parameter int FRAME_HEIGHT = cqb_pkg::FRAME_HEIGHT_DEF,
   parameter int ATLAS_SIZE   = cqb_pkg::ATLAS_SIZE_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  cqb_pkg::cqb_req_type                req_item,
   input  logic                                csr_write_en,
   input  logic [cqb_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [cqb_pkg::COORD_W-1:0]         csr_wdata,
   input  cqb_pkg::cqb_cmd_type                cmd,
   output cqb_pkg::cqb_sts_type                sts,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output cqb_pkg::cqb_rsp_type                rsp_item
);

   localparam int SW     = cqb_pkg::SPAN_W;
   localparam int CW     = cqb_pkg::COORD_W;
   localparam int TW     = cqb_pkg::TEXEL_W;
   localparam int XW     = $clog2(FRAME_WIDTH);
   localparam int YW     = $clog2(FRAME_HEIGHT);
   localparam int FDEPTH = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int FAW    = $clog2(FDEPTH);
   localparam int ADEPTH = ATLAS_SIZE * ATLAS_SIZE;
   localparam int AAW    = $clog2(ADEPTH);
   localparam logic signed [SW-1:0] FW_S = SW'(FRAME_WIDTH);
   localparam logic signed [SW-1:0] FH_S = SW'(FRAME_HEIGHT);
   localparam logic [TW-1:0] AS_T = TW'(ATLAS_SIZE);
   localparam logic [FAW-1:0] FW_A = FAW'(FRAME_WIDTH);
   localparam logic [AAW-1:0] AS_A = AAW'(ATLAS_SIZE);
   localparam logic [FAW-1:0] CLEAR_LAST = FAW'(FDEPTH - 1);

   function automatic logic signed [SW-1:0] sext(input logic [CW-1:0] v);
      sext = $signed({{(SW-CW){v[CW-1]}}, v});
   endfunction

   function automatic logic signed [SW-1:0] zext(input logic [CW-1:0] v);
      zext = $signed({{(SW-CW){1'b0}}, v});
   endfunction

   function automatic logic signed [SW-1:0] smax(input logic signed [SW-1:0] a,
                                                 input logic signed [SW-1:0] b);
      smax = (a > b) ? a : b;
   endfunction

   function automatic logic signed [SW-1:0] smin(input logic signed [SW-1:0] a,
                                                 input logic signed [SW-1:0] b);
      smin = (a < b) ? a : b;
   endfunction

   // configuration
   logic [CW-1:0] clip_left_ff, clip_top_ff, clip_width_ff, clip_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_left_ff   <= '0;
         clip_top_ff    <= '0;
         clip_width_ff  <= cqb_pkg::CLIP_SIZE_RESET;
         clip_height_ff <= cqb_pkg::CLIP_SIZE_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            cqb_pkg::CSR_CLIP_LEFT:   clip_left_ff   <= csr_wdata;
            cqb_pkg::CSR_CLIP_TOP:    clip_top_ff    <= csr_wdata;
            cqb_pkg::CSR_CLIP_WIDTH:  clip_width_ff  <= csr_wdata;
            cqb_pkg::CSR_CLIP_HEIGHT: clip_height_ff <= csr_wdata;
         endcase
      end
   end

   // item register
   cqb_pkg::cqb_req_type item_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         item_ff <= req_item;
      end
   end

   // rectangle setup
   logic signed [SW-1:0] dx_s, dy_s, cl_s, ct_s;
   logic signed [SW-1:0] xs_c, xe_c, ys_c, ye_c, xl_c, yl_c, xoff_c, yoff_c;
   logic                 empty_c, textured_c, read_ok_c, load_ok_c;
   logic [TW-1:0]        tcol0_c, trow0_c;
   logic [FAW-1:0]       read_addr;
   logic [AAW-1:0]       load_addr;

   always_comb begin
      dx_s       = sext(item_ff.dest_x);
      dy_s       = sext(item_ff.dest_y);
      cl_s       = sext(clip_left_ff);
      ct_s       = sext(clip_top_ff);
      xs_c       = smax(smax(dx_s, cl_s), '0);
      ys_c       = smax(smax(dy_s, ct_s), '0);
      xe_c       = smin(smin(dx_s + zext(item_ff.dest_w), cl_s + zext(clip_width_ff)), FW_S);
      ye_c       = smin(smin(dy_s + zext(item_ff.dest_h), ct_s + zext(clip_height_ff)), FH_S);
      xl_c       = xe_c - SW'(1);
      yl_c       = ye_c - SW'(1);
      empty_c    = (xs_c >= xe_c) || (ys_c >= ye_c);
      xoff_c     = xs_c - dx_s;
      yoff_c     = ys_c - dy_s;
      tcol0_c    = TW'(item_ff.tex_x) + xoff_c[TW-1:0];
      trow0_c    = TW'(item_ff.tex_y) + yoff_c[TW-1:0];
      textured_c = (CW'(item_ff.tex_w) == item_ff.dest_w) &&
                   (CW'(item_ff.tex_h) == item_ff.dest_h);
      read_ok_c  = !item_ff.dest_x[CW-1] && !item_ff.dest_y[CW-1] &&
                   (dx_s < FW_S) && (dy_s < FH_S);
      read_addr  = FAW'(FAW'(item_ff.dest_y[YW-1:0]) * FW_A) +
                   FAW'(item_ff.dest_x[XW-1:0]);
      load_ok_c  = (TW'(item_ff.tex_x) < AS_T) && (TW'(item_ff.tex_y) < AS_T);
      load_addr  = AAW'(AAW'(item_ff.tex_y) * AS_A) + AAW'(item_ff.tex_x);
   end

   // pixel walker
   logic [XW-1:0]  xs_ff, xl_ff, x_ff;
   logic [YW-1:0]  ys_ff, yl_ff, y_ff;
   logic [TW-1:0]  tcol0_ff, tcol_ff, trow_ff;
   logic [FAW-1:0] fbase_ff;
   logic [AAW-1:0] abase_ff;
   logic           empty_ff, textured_ff, read_ok_ff;
   logic [cqb_pkg::COUNT_W-1:0] count_ff;
   logic           row_end, step;

   assign row_end = (x_ff == xl_ff);
   assign step    = cmd.fill_step || cmd.tex_wr;

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         xs_ff       <= xs_c[XW-1:0];
         xl_ff       <= xl_c[XW-1:0];
         ys_ff       <= ys_c[YW-1:0];
         yl_ff       <= yl_c[YW-1:0];
         tcol0_ff    <= tcol0_c;
         trow_ff     <= trow0_c;
         empty_ff    <= empty_c;
         textured_ff <= textured_c;
         read_ok_ff  <= read_ok_c;
         count_ff    <= '0;
      end else if (cmd.start) begin
         x_ff     <= xs_ff;
         y_ff     <= ys_ff;
         tcol_ff  <= tcol0_ff;
         fbase_ff <= FAW'(FAW'(ys_ff) * FW_A);
         abase_ff <= AAW'(AAW'(trow_ff) * AS_A);
      end else if (step) begin
         if (count_ff != '1) begin
            count_ff <= count_ff + 1'b1;
         end
         if (row_end) begin
            x_ff     <= xs_ff;
            y_ff     <= y_ff + 1'b1;
            tcol_ff  <= tcol0_ff;
            trow_ff  <= trow_ff + 1'b1;
            fbase_ff <= fbase_ff + FW_A;
            abase_ff <= abase_ff + AS_A;
         end else begin
            x_ff    <= x_ff + 1'b1;
            tcol_ff <= tcol_ff + 1'b1;
         end
      end
   end

   // clearing pass
   logic [FAW-1:0] clear_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff <= '0;
      end else if (cmd.clear_step) begin
         clear_ff <= clear_ff + 1'b1;
      end
   end

   // memories
   logic [FAW-1:0]                  pix_addr, f_waddr, f_raddr;
   logic [cqb_pkg::PIXEL_W-1:0]     f_wdata, f_rdata;
   logic                            f_we, a_we, tex_ok;
   logic [AAW-1:0]                  a_raddr;
   logic [cqb_pkg::COLOUR_W-1:0]    a_rdata, grey;

   assign pix_addr = fbase_ff + FAW'(x_ff);
   assign a_raddr  = abase_ff + AAW'(tcol_ff);
   assign tex_ok   = (tcol_ff < AS_T) && (trow_ff < AS_T);
   assign grey     = tex_ok ? a_rdata : '0;

   always_comb begin
      f_we    = cmd.clear_step || cmd.fill_step || cmd.tex_wr;
      f_waddr = cmd.clear_step ? clear_ff : pix_addr;
      if (cmd.clear_step) begin
         f_wdata = '0;
      end else if (cmd.fill_step) begin
         f_wdata = {item_ff.red, item_ff.green, item_ff.blue};
      end else begin
         f_wdata = f_rdata | {grey, grey, grey};
      end
      f_raddr = (item_ff.action == cqb_pkg::ACT_READ) ? read_addr : pix_addr;
      a_we    = cmd.setup && (item_ff.action == cqb_pkg::ACT_LOAD) && load_ok_c;
   end

   cqb_ram #(
      .WIDTH (cqb_pkg::PIXEL_W),
      .DEPTH (FDEPTH)
   ) u_frame_ram (
      .clock      (clock),
      .write_en   (f_we),
      .write_addr (f_waddr),
      .write_data (f_wdata),
      .read_addr  (f_raddr),
      .read_data  (f_rdata)
   );

   cqb_ram #(
      .WIDTH (cqb_pkg::COLOUR_W),
      .DEPTH (ADEPTH)
   ) u_atlas_ram (
      .clock      (clock),
      .write_en   (a_we),
      .write_addr (load_addr),
      .write_data (item_ff.red),
      .read_addr  (a_raddr),
      .read_data  (a_rdata)
   );

   // result register
   logic                 rsp_valid_ff;
   cqb_pkg::cqb_rsp_type rsp_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_item_ff.pixel_value  <= (item_ff.action == cqb_pkg::ACT_READ && read_ok_ff) ?
                                     f_rdata : '0;
         rsp_item_ff.pixels_drawn <= (item_ff.action == cqb_pkg::ACT_DRAW) ? count_ff : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   always_comb begin
      sts.clear_done = (clear_ff == CLEAR_LAST);
      sts.is_draw    = (item_ff.action == cqb_pkg::ACT_DRAW);
      sts.empty      = empty_ff;
      sts.textured   = textured_ff;
      sts.last_pixel = row_end && (y_ff == yl_ff);
      sts.out_free   = !rsp_valid_ff || !rsp_stall;
   end

endmodule

// File: rtl/clipped_quad_blitter.sv
// ----------------------------------------------------------------------------
// Clipped quad blitter
// 2D blitter: clipped colour fill or grey atlas blit into an RGB framebuffer.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item (draw quad, load atlas byte, read pixel); it is
//   taken at an edge with req_valid high and req_stall low. Every item gives
//   exactly one rsp_* item, delivered in order under the same handshake.
//   csr_* writes the clip rectangle, one register per cycle; the user must
//   write it only while idle, as the block itself does not enforce this.
//   A textured quad does a frame read-modify-write per pixel, through a read
//   state and a write state, with one memory port per direction.
//   A new item is taken only once the previous one has finished, as
//   req_stall stays high until then.
//   After reset the frame store is cleared one pixel per cycle, with
//   req_stall held high; clip writes are still taken. A stalled result holds
//   in its output register; the next item may be accepted and processed
//   meanwhile, then waits.
// ----------------------------------------------------------------------------
module clipped_quad_blitter #(
   parameter int FRAME_WIDTH  = cqb_pkg::FRAME_WIDTH_DEF,
   parameter int FRAME_HEIGHT = cqb_pkg::FRAME_HEIGHT_DEF,
   parameter int ATLAS_SIZE   = cqb_pkg::ATLAS_SIZE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  cqb_pkg::cqb_req_type            req_item,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output cqb_pkg::cqb_rsp_type            rsp_item,
   input  logic                            csr_write_en,
   input  logic [cqb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cqb_pkg::COORD_W-1:0]     csr_wdata
);

   cqb_pkg::cqb_cmd_type cmd;
   cqb_pkg::cqb_sts_type sts;

   cqb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   cqb_datapath #(
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT),
      .ATLAS_SIZE   (ATLAS_SIZE)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_item     (req_item),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_item     (rsp_item)
   );

endmodule

// File: rtl/cqb_checker.sv
// ----------------------------------------------------------------------------
// Clipped quad blitter checker
// Port-level assertions on items in flight, result hold and reset, bound to the top level.
// ----------------------------------------------------------------------------
`include "clipped_quad_blitter_assert.svh"

module cqb_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input cqb_pkg::cqb_rsp_type rsp_item
);

   // items accepted but not yet delivered
   logic [1:0] pending_ff;
   logic [1:0] pending_in;

   always_comb begin
      pending_in = pending_ff;
      if (req_valid && !req_stall) begin
         pending_in = pending_in + 1'b1;
      end
      if (rsp_valid && !rsp_stall) begin
         pending_in = pending_in - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `CQB_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item), "stalled result changed")
   `CQB_ASSERT_ALWAYS(a_reset_stall, reset |=> req_stall, "item taken during clearing pass")
   `CQB_ASSERT(a_no_spurious, rsp_valid |-> pending_ff != 2'd0, "result without an item")
   `CQB_ASSERT(a_pending_depth, pending_ff != 2'd3, "too many items in flight")

endmodule

bind clipped_quad_blitter cqb_checker u_cqb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);

// File: tb/blit_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Clipped quad blitter checker
// Watches the item, result and clip register ports of the blitter. Keeps its
// own frame, atlas and clip window, works out the result of every accepted
// item and compares each delivered result with the oldest one outstanding.
// ----------------------------------------------------------------------------
module blit_checker
   import cqb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  cqb_req_type            req_item,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  cqb_rsp_type            rsp_item,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COORD_W-1:0]     csr_wdata,
   output int                     outstanding,
   output int                     mismatches
);

   localparam int FRAME_W     = FRAME_WIDTH_DEF;
   localparam int FRAME_H     = FRAME_HEIGHT_DEF;
   localparam int ATLAS_N     = ATLAS_SIZE_DEF;
   localparam longint COUNT_SAT = 2 ** COUNT_W - 1;

   logic [PIXEL_W-1:0]  frame_mirror [int];
   logic [COLOUR_W-1:0] atlas_mirror [ATLAS_N * ATLAS_N];
   int                  clip_left, clip_top, clip_width, clip_height;
   cqb_rsp_type         pending_results [$];

   function automatic cqb_rsp_type predict_blit(input cqb_req_type it);
      cqb_rsp_type        res;
      int                 dx, dy, dw, dh, tx, ty, xs, xe, ys, ye, col, row, idx;
      logic [7:0]         grey;
      logic [PIXEL_W-1:0] old_px;
      longint             count;
      bit                 textured;
      res   = '0;
      count = 0;
      dx    = int'($signed(it.dest_x));
      dy    = int'($signed(it.dest_y));
      dw    = int'(it.dest_w);
      dh    = int'(it.dest_h);
      tx    = int'(it.tex_x);
      ty    = int'(it.tex_y);
      case (it.action)
         ACT_DRAW: begin
            textured = (it.dest_w == it.tex_w) && (it.dest_h == it.tex_h);
            xs = (dx > clip_left) ? dx : clip_left;
            if (xs < 0) xs = 0;
            xe = (dx + dw < clip_left + clip_width) ? dx + dw : clip_left + clip_width;
            if (xe > FRAME_W) xe = FRAME_W;
            ys = (dy > clip_top) ? dy : clip_top;
            if (ys < 0) ys = 0;
            ye = (dy + dh < clip_top + clip_height) ? dy + dh : clip_top + clip_height;
            if (ye > FRAME_H) ye = FRAME_H;
            for (int y = ys; y < ye; y++) begin
               for (int x = xs; x < xe; x++) begin
                  idx = y * FRAME_W + x;
                  if (textured) begin
                     col  = tx + x - dx;
                     row  = ty + y - dy;
                     grey = (col < ATLAS_N && row < ATLAS_N) ?
                            atlas_mirror[row * ATLAS_N + col] : 8'h00;
                     old_px = frame_mirror.exists(idx) ? frame_mirror[idx] : '0;
                     frame_mirror[idx] = old_px | {grey, grey, grey};
                  end else begin
                     frame_mirror[idx] = {it.red, it.green, it.blue};
                  end
                  count++;
               end
            end
            res.pixels_drawn = (count > COUNT_SAT) ? COUNT_W'(COUNT_SAT) : COUNT_W'(count);
         end
         ACT_LOAD: begin
            atlas_mirror[ty * ATLAS_N + tx] = it.red;
         end
         ACT_READ: begin
            idx = dy * FRAME_W + dx;
            if (dx >= 0 && dy >= 0 && dx < FRAME_W && dy < FRAME_H &&
                frame_mirror.exists(idx))
               res.pixel_value = frame_mirror[idx];
         end
         default: ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      cqb_rsp_type want;
      if (reset) begin
         clip_left   = 0;
         clip_top    = 0;
         clip_width  = int'(CLIP_SIZE_RESET);
         clip_height = int'(CLIP_SIZE_RESET);
         frame_mirror.delete();
         pending_results.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_CLIP_LEFT:   clip_left   = int'($signed(csr_wdata));
               CSR_CLIP_TOP:    clip_top    = int'($signed(csr_wdata));
               CSR_CLIP_WIDTH:  clip_width  = int'(csr_wdata);
               CSR_CLIP_HEIGHT: clip_height = int'(csr_wdata);
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result with no item outstanding: pixel_value %h pixels_drawn %0d",
                           $time, rsp_item.pixel_value, rsp_item.pixels_drawn);
            end else begin
               want = pending_results.pop_front();
               if (rsp_item.pixel_value !== want.pixel_value ||
                   rsp_item.pixels_drawn !== want.pixels_drawn) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: pixel_value %h (expected %h), pixels_drawn %0d (expected %0d)",
                              $time, rsp_item.pixel_value, want.pixel_value,
                              rsp_item.pixels_drawn, want.pixels_drawn);
               end
            end
         end
         if (req_valid && !req_stall)
            pending_results.push_back(predict_blit(req_item));
      end
      outstanding <= pending_results.size();
   end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Clipped quad blitter testbench
// Directed items for frame edges, empty quads, textured blits over fills and
// texels off the atlas, then random phases under varied clip windows with
// random idle gaps on both channels. Atlas bytes are loaded before any
// textured quad reads them.
// ----------------------------------------------------------------------------
module tb_top;
   import cqb_pkg::*;

   localparam int FRAME_W     = FRAME_WIDTH_DEF;
   localparam int FRAME_H     = FRAME_HEIGHT_DEF;
   localparam int ATLAS_N     = ATLAS_SIZE_DEF;
   localparam int ITEM_TARGET = 700;
   localparam int PHASE_ITEMS = 90;
   localparam int AREA_CAP    = 600;
   localparam int COORD_MIN   = -(2 ** (COORD_W - 1));
   localparam int COORD_MAX   = 2 ** (COORD_W - 1) - 1;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   logic                   clock        = 1'b0;
   logic                   reset        = 1'b1;
   logic                   req_valid    = 1'b0;
   logic                   req_stall;
   cqb_req_type            req_item     = '0;
   logic                   rsp_valid;
   logic                   rsp_stall    = 1'b0;
   cqb_rsp_type            rsp_item;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index    = '0;
   logic [COORD_W-1:0]     csr_wdata    = '0;

   int outstanding, mismatches;
   bit calm;
   int items_sent;
   bit atlas_loaded [ATLAS_N * ATLAS_N];
   int clip_l = 0, clip_t = 0, clip_w = 1024, clip_h = 1024;
   bit hit_valid;
   int hit_xs, hit_xe, hit_ys, hit_ye;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   clipped_quad_blitter dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_item     (req_item),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_item     (rsp_item),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   blit_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_item     (req_item),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_item     (rsp_item),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .outstanding  (outstanding),
      .mismatches   (mismatches)
   );

   initial begin
      #144_000_000;
      $display("** clipped_quad_blitter: FAILED **");
      $finish;
   end

   // result side back-pressure
   initial begin
      int hold;
      @(posedge clock);
      forever begin
         hold = calm ? 0 : int'($urandom_range(0, 11));
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   function automatic cqb_req_type random_item();
      cqb_req_type it;
      logic [127:0] bits;
      bits     = {$urandom, $urandom, $urandom, $urandom};
      it       = bits[$bits(cqb_req_type)-1:0];
      it.tex_w = TEX_SIZE_W'($urandom_range(0, 128));
      it.tex_h = TEX_SIZE_W'($urandom_range(0, 128));
      return it;
   endfunction

   function automatic cqb_req_type mk(input logic [1:0] act, input int x, input int y,
                                      input int w, input int h, input int tx, input int ty,
                                      input int tw, input int th,
                                      input logic [PIXEL_W-1:0] colour);
      cqb_req_type it;
      it.action = act;
      it.dest_x = x[COORD_W-1:0];
      it.dest_y = y[COORD_W-1:0];
      it.dest_w = w[COORD_W-1:0];
      it.dest_h = h[COORD_W-1:0];
      it.tex_x  = tx[TEX_POS_W-1:0];
      it.tex_y  = ty[TEX_POS_W-1:0];
      it.tex_w  = tw[TEX_SIZE_W-1:0];
      it.tex_h  = th[TEX_SIZE_W-1:0];
      it.red    = colour[23:16];
      it.green  = colour[15:8];
      it.blue   = colour[7:0];
      return it;
   endfunction

   // coordinate close to a clip or frame edge, or anywhere on the frame
   function automatic logic [COORD_W-1:0] near_spot(input int lo, input int span,
                                                   input int frame_n);
      int base;
      case ($urandom_range(0, 4))
         0:       base = lo;
         1:       base = lo + span;
         2:       base = 0;
         3:       base = frame_n;
         default: base = int'($urandom_range(0, frame_n - 1));
      endcase
      base = base + int'($urandom_range(0, 40)) - 20;
      if (base < COORD_MIN) base = COORD_MIN;
      else if (base > COORD_MAX) base = COORD_MAX;
      return base[COORD_W-1:0];
   endfunction

   function automatic int clipped_area(input cqb_req_type it, output int xs, output int xe,
                                       output int ys, output int ye);
      int dx, dy;
      dx = int'($signed(it.dest_x));
      dy = int'($signed(it.dest_y));
      xs = (dx > clip_l) ? dx : clip_l;
      if (xs < 0) xs = 0;
      xe = (dx + int'(it.dest_w) < clip_l + clip_w) ? dx + int'(it.dest_w) : clip_l + clip_w;
      if (xe > FRAME_W) xe = FRAME_W;
      ys = (dy > clip_t) ? dy : clip_t;
      if (ys < 0) ys = 0;
      ye = (dy + int'(it.dest_h) < clip_t + clip_h) ? dy + int'(it.dest_h) : clip_t + clip_h;
      if (ye > FRAME_H) ye = FRAME_H;
      if (xe <= xs || ye <= ys) return 0;
      return (xe - xs) * (ye - ys);
   endfunction

   task automatic push_item(input cqb_req_type it);
      int gap;
      gap = calm ? 0 : int'($urandom_range(0, 11));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (req_stall !== 1'b0);
      if (it.action == ACT_LOAD)
         atlas_loaded[int'(it.tex_y) * ATLAS_N + int'(it.tex_x)] = 1'b1;
      items_sent++;
   endtask

   // textured quads get every covered atlas byte loaded first
   task automatic issue(input cqb_req_type it);
      int xs, xe, ys, ye, col, row;
      cqb_req_type load;
      if (it.action == ACT_DRAW && clipped_area(it, xs, xe, ys, ye) > 0) begin
         hit_valid = 1'b1;
         hit_xs    = xs;
         hit_xe    = xe;
         hit_ys    = ys;
         hit_ye    = ye;
         if (it.dest_w == it.tex_w && it.dest_h == it.tex_h) begin
            for (int y = ys; y < ye; y++) begin
               for (int x = xs; x < xe; x++) begin
                  col = int'(it.tex_x) + x - int'($signed(it.dest_x));
                  row = int'(it.tex_y) + y - int'($signed(it.dest_y));
                  if (col < ATLAS_N && row < ATLAS_N && !atlas_loaded[row * ATLAS_N + col]) begin
                     load        = random_item();
                     load.action = ACT_LOAD;
                     load.tex_x  = col[TEX_POS_W-1:0];
                     load.tex_y  = row[TEX_POS_W-1:0];
                     push_item(load);
                  end
               end
            end
         end
      end
      push_item(it);
   endtask

   task automatic set_clip(input int left, input int top_edge, input int width,
                           input int height);
      logic [CSR_INDEX_W-1:0] regs [4];
      int vals [4];
      regs = '{CSR_CLIP_LEFT, CSR_CLIP_TOP, CSR_CLIP_WIDTH, CSR_CLIP_HEIGHT};
      vals = '{left, top_edge, width, height};
      for (int i = 0; i < 4; i++) begin
         csr_write_en <= 1'b1;
         csr_index    <= regs[i];
         csr_wdata    <= vals[i][COORD_W-1:0];
         @(posedge clock);
      end
      csr_write_en <= 1'b0;
      clip_l = left;
      clip_t = top_edge;
      clip_w = width;
      clip_h = height;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin
      cqb_req_type it;
      int pick, phase, phase_end, step, xs, xe, ys, ye;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // default clip window
      issue(mk(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 24'h0));
      issue(mk(ACT_READ, -2048, -2048, 0, 0, 0, 0, 0, 0, 24'h0));
      issue(mk(ACT_READ, 2047, 2047, 0, 0, 0, 0, 0, 0, 24'h0));
      issue(mk(ACT_DRAW, 1020, 1021, 10, 10, 0, 0, 0, 0, 24'hff8001));
      issue(mk(ACT_READ, 1023, 1023, 0, 0, 0, 0, 0, 0, 24'h0));
      issue(mk(ACT_READ, 1024, 5, 0, 0, 0, 0, 0, 0, 24'h0));
      issue(mk(ACT_READ, -1, 0, 0, 0, 0, 0, 0, 0, 24'h0));
      issue(mk(ACT_DRAW, 40, 40, 0, 7, 0, 0, 3, 3, 24'h123456));
      issue(mk(ACT_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 24'h810000));
      issue(mk(ACT_LOAD, 0, 0, 0, 0, 1, 0, 0, 0, 24'h7e0000));
      issue(mk(ACT_LOAD, 0, 0, 0, 0, 127, 127, 0, 0, 24'hff0000));
      issue(mk(ACT_DRAW, 1022, 0, 2, 1, 0, 0, 2, 1, 24'hffffff));
      issue(mk(ACT_READ, 1023, 0, 0, 0, 0, 0, 0, 0, 24'h0));
      issue(mk(ACT_DRAW, 10, 10, 2, 2, 0, 0, 1, 1, 24'h0f0f0f));
      issue(mk(ACT_DRAW, 10, 10, 1, 1, 0, 0, 1, 1, 24'h0));
      issue(mk(ACT_READ, 10, 10, 0, 0, 0, 0, 0, 0, 24'h0));
      issue(mk(ACT_DRAW, 20, 20, 2, 2, 127, 127, 2, 2, 24'h0));
      issue(mk(ACT_READ, 20, 20, 0, 0, 0, 0, 0, 0, 24'h0));
      issue(mk(ACT_READ, 21, 21, 0, 0, 0, 0, 0, 0, 24'h0));
      issue(mk(ACT_UNUSED, 5, 5, 5, 5, 5, 5, 5, 5, 24'habcdef));
      drain();

      // tiny clip window against quads of the full field range
      set_clip(5, 7, 3, 2);
      issue(mk(ACT_DRAW, -2048, -2048, 4095, 4095, 0, 0, 128, 128, 24'h00ff00));
      issue(mk(ACT_DRAW, 2047, 2047, 4095, 4095, 0, 0, 0, 0, 24'h0000ff));
      issue(mk(ACT_DRAW, 5, 7, 128, 128, 0, 0, 128, 128, 24'h0));
      issue(mk(ACT_READ, 6, 8, 0, 0, 0, 0, 0, 0, 24'h0));

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         drain();
         case (phase)
            0:       set_clip(0, 0, 1024, 1024);
            1:       set_clip(-2048, -2048, 4095, 4095);
            2:       set_clip(100, 200, 64, 48);
            3:       set_clip(2047, 2047, 4095, 4095);
            4:       set_clip(-5, -3, 40, 30);
            5:       set_clip(1000, 1010, 4095, 4095);
            6:       set_clip(0, 0, 0, 0);
            default: set_clip(int'($urandom_range(0, 1100)) - 64,
                              int'($urandom_range(0, 1100)) - 64,
                              int'($urandom_range(0, 160)), int'($urandom_range(0, 160)));
         endcase
         phase++;
         phase_end = items_sent + PHASE_ITEMS;
         step = 0;
         while (items_sent < phase_end) begin
            if (step % 30 == 0) calm = ($urandom_range(0, 3) == 0);
            step++;
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
               do begin
                  it        = random_item();
                  it.action = ACT_DRAW;
                  if ($urandom_range(0, 4) != 0) begin
                     it.dest_x = near_spot(clip_l, clip_w, FRAME_W);
                     it.dest_y = near_spot(clip_t, clip_h, FRAME_H);
                     it.dest_w = COORD_W'($urandom_range(0, 24));
                     it.dest_h = COORD_W'($urandom_range(0, 24));
                  end
                  if (pick >= 35) begin
                     it.tex_w  = ($urandom_range(0, 15) == 0) ? TEX_SIZE_W'(128) :
                                 TEX_SIZE_W'($urandom_range(0, 12));
                     it.tex_h  = ($urandom_range(0, 15) == 0) ? TEX_SIZE_W'(128) :
                                 TEX_SIZE_W'($urandom_range(0, 12));
                     it.dest_w = COORD_W'(it.tex_w);
                     it.dest_h = COORD_W'(it.tex_h);
                     it.tex_x  = ($urandom_range(0, 3) == 0) ?
                                 TEX_POS_W'($urandom_range(100, 127)) :
                                 TEX_POS_W'($urandom_range(0, 31));
                     it.tex_y  = ($urandom_range(0, 3) == 0) ?
                                 TEX_POS_W'($urandom_range(100, 127)) :
                                 TEX_POS_W'($urandom_range(0, 31));
                  end
               end while (clipped_area(it, xs, xe, ys, ye) > AREA_CAP);
            end else if (pick < 77) begin
               it        = random_item();
               it.action = ACT_LOAD;
            end else if (pick < 97) begin
               it        = random_item();
               it.action = ACT_READ;
               pick      = $urandom_range(0, 9);
               if (pick < 5 && hit_valid) begin
                  it.dest_x = COORD_W'($urandom_range(hit_xs, hit_xe - 1));
                  it.dest_y = COORD_W'($urandom_range(hit_ys, hit_ye - 1));
               end else if (pick < 8) begin
                  it.dest_x = near_spot(clip_l, clip_w, FRAME_W);
                  it.dest_y = near_spot(clip_t, clip_h, FRAME_H);
               end
            end else begin
               it        = random_item();
               it.action = ACT_UNUSED;
            end
            issue(it);
         end
      end

      calm = 1'b0;
      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("** clipped_quad_blitter: PASSED **");
      else
         $display("** clipped_quad_blitter: FAILED **");
      $finish;
   end

endmodule
